FILE: design/bsm_pkg.sv
// ----------------------------------------------------------------------------
// bsm_pkg - shared types and constants for the bounding sphere merge
// Widths of the digit-serial units, the sequencer states and the unit
// control bundle.
// ----------------------------------------------------------------------------
`default_nettype none
package bsm_pkg;

  localparam int unsigned CoordW    = 32;  // signed Q16.16 centre
  localparam int unsigned RadW      = 31;  // unsigned Q15.16 radius
  localparam int unsigned MagW      = CoordW + 1;  // |acc - in| per axis
  localparam int unsigned ProdW     = 2 * MagW;    // product / sum of squares
  localparam int unsigned LenW      = MagW;        // floor sqrt of the sum
  localparam int unsigned QuotW     = 31;          // factor, Q1.30, at most 2^30
  localparam int unsigned ExcessW   = LenW + 1;    // l + r - R
  localparam int unsigned PBits     = 30;
  localparam int unsigned MulSteps  = MagW;
  localparam int unsigned RootSteps = ProdW / 2;
  localparam int unsigned DivSteps  = QuotW;
  localparam int unsigned CntW      = 6;

  localparam logic [RadW-1:0] RadMax = {RadW{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_SLD,
    S_SQR,
    S_SUM,
    S_ROOT,
    S_DEC,
    S_DIV,
    S_MLD,
    S_MUL,
    S_UPD,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
  } unit_ctrl_t;

endpackage
`default_nettype wire

FILE: design/bsm_lane.sv
// ----------------------------------------------------------------------------
// bsm_lane - bit-serial shift-add multiplier for one axis
// One multiplier bit per cycle, LSB first; MulSteps steps give a full product.
// ----------------------------------------------------------------------------
`default_nettype none
module bsm_lane (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  bsm_pkg::unit_ctrl_t         ctrl_i,
  input  wire  [bsm_pkg::MagW-1:0]    a_i,
  input  wire  [bsm_pkg::MagW-1:0]    b_i,
  output logic [bsm_pkg::ProdW-1:0]   prod_o
);
  import bsm_pkg::*;

  logic [ProdW-1:0] a_q, prod_q;
  logic [MagW-1:0]  b_q;

  // shift the multiplicand up, the multiplier down, add on a set bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      b_q    <= '0;
      prod_q <= '0;
    end else if (ctrl_i.load) begin
      a_q    <= {{(ProdW-MagW){1'b0}}, a_i};
      b_q    <= b_i;
      prod_q <= '0;
    end else if (ctrl_i.step) begin
      if (b_q[0]) begin
        prod_q <= prod_q + a_q;
      end
      a_q <= {a_q[ProdW-2:0], 1'b0};
      b_q <= {1'b0, b_q[MagW-1:1]};
    end
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

FILE: design/bsm_sqrt.sv
// ----------------------------------------------------------------------------
// bsm_sqrt - digit-by-digit integer square root
// Two radicand bits per cycle, one root bit per cycle, RootSteps steps.
// ----------------------------------------------------------------------------
`default_nettype none
module bsm_sqrt (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  bsm_pkg::unit_ctrl_t         ctrl_i,
  input  wire  [bsm_pkg::ProdW-1:0]   val_i,
  output logic [bsm_pkg::LenW-1:0]    root_o
);
  import bsm_pkg::*;

  logic [ProdW-1:0] rad_q;
  logic [LenW:0]    rem_q;
  logic [LenW-1:0]  root_q;
  logic [LenW+2:0]  cur, trial;

  assign cur   = {rem_q, rad_q[ProdW-1:ProdW-2]};
  assign trial = {root_q, 2'b01};

  // bring down two bits, try the next root bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else if (ctrl_i.load) begin
      rad_q  <= val_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (ctrl_i.step) begin
      rad_q <= {rad_q[ProdW-3:0], 2'b00};
      if (cur >= trial) begin
        rem_q  <= (LenW+1)'(cur - trial);
        root_q <= {root_q[LenW-2:0], 1'b1};
      end else begin
        rem_q  <= cur[LenW:0];
        root_q <= {root_q[LenW-2:0], 1'b0};
      end
    end
  end

  assign root_o = root_q;

endmodule
`default_nettype wire

FILE: design/bsm_div.sv
// ----------------------------------------------------------------------------
// bsm_div - restoring divider for the centre shift factor
// Computes ((e << 29) / l), one quotient bit per cycle, DivSteps steps.
// ----------------------------------------------------------------------------
`default_nettype none
module bsm_div (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  bsm_pkg::unit_ctrl_t          ctrl_i,
  input  wire  [bsm_pkg::ExcessW-1:0]  e_i,
  input  wire  [bsm_pkg::LenW-1:0]     l_i,
  output logic [bsm_pkg::QuotW-1:0]    q_o
);
  import bsm_pkg::*;

  logic [LenW-1:0]  rem_q, den_q;
  logic [QuotW-1:0] num_q, q_q;
  logic [LenW:0]    cur;

  assign cur = {rem_q, num_q[QuotW-1]};

  // high numerator bits start the remainder, the rest shift in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      den_q <= '0;
      num_q <= '0;
      q_q   <= '0;
    end else if (ctrl_i.load) begin
      rem_q <= LenW'(e_i[ExcessW-1:2]);
      den_q <= l_i;
      num_q <= {e_i[1:0], {(QuotW-2){1'b0}}};
      q_q   <= '0;
    end else if (ctrl_i.step) begin
      num_q <= {num_q[QuotW-2:0], 1'b0};
      if (cur >= {1'b0, den_q}) begin
        rem_q <= LenW'(cur - {1'b0, den_q});
        q_q   <= {q_q[QuotW-2:0], 1'b1};
      end else begin
        rem_q <= cur[LenW-1:0];
        q_q   <= {q_q[QuotW-2:0], 1'b0};
      end
    end
  end

  assign q_o = q_q;

endmodule
`default_nettype wire

FILE: design/bounding_sphere_merge.sv
// ----------------------------------------------------------------------------
// bounding_sphere_merge - running enclosing sphere of a sphere stream
// Digit-serial sequencer: serial squares, serial root, serial divide and
// serial centre shift, one bit per cycle in each unit.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_ready_o | start_new, centre x/y/z, radius
//  out     | output    | out_valid_o/out_ready_i | centre x/y/z, radius, overflow
//
//  A start item shows its result in the cycle after its transfer. A merge
//  that needs no centre shift (coincident, enclosed or enclosing) loads the
//  lanes, runs the squares, loads and runs the root and decides. A partial
//  overlap then also runs the divide, loads the lanes, runs the centre
//  shift and updates. One item at a time: in_ready_o is high only while no
//  item is in flight. Reset clears the running sphere to centre 0, radius 0.
//  A stalled result holds until transferred.
// ----------------------------------------------------------------------------
`default_nettype none
module bounding_sphere_merge (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire                          start_new_i,
  input  wire  [bsm_pkg::CoordW-1:0]   in_center_x_i,
  input  wire  [bsm_pkg::CoordW-1:0]   in_center_y_i,
  input  wire  [bsm_pkg::CoordW-1:0]   in_center_z_i,
  input  wire  [bsm_pkg::RadW-1:0]     in_radius_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [bsm_pkg::CoordW-1:0]   out_center_x_o,
  output logic [bsm_pkg::CoordW-1:0]   out_center_y_o,
  output logic [bsm_pkg::CoordW-1:0]   out_center_z_o,
  output logic [bsm_pkg::RadW-1:0]     out_radius_o,
  output logic                         overflow_o
);
  import bsm_pkg::*;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [CoordW-1:0] acc_c_q [3];
  logic [CoordW-1:0] cin_q   [3];
  logic [CoordW-1:0] in_c    [3];
  logic [MagW-1:0]   mag_q   [3];
  logic              neg_q   [3];
  logic [ProdW-1:0]  prod    [3];
  logic [RadW-1:0]   acc_r_q, rin_q;
  logic              ovf_q;

  unit_ctrl_t lane_ctrl, root_ctrl, div_ctrl;
  logic [ProdW-1:0]  sum_sq;
  logic [LenW-1:0]   len;
  logic [QuotW-1:0]  quot;
  logic [ExcessW-1:0] len_r, excess;
  logic [ExcessW:0]  tot;
  logic [RadW-1:0]   rad_half_lo;
  logic              rad_sat;
  logic              in_xfer;

  assign in_c[0] = in_center_x_i;
  assign in_c[1] = in_center_y_i;
  assign in_c[2] = in_center_z_i;
  assign in_xfer = in_valid_i && in_ready_o;

  // per-axis serial multipliers
  for (genvar g = 0; g < 3; g++) begin : g_lane
    bsm_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (lane_ctrl),
      .a_i    (mag_q[g]),
      .b_i    ((state_q == S_SLD) ? mag_q[g] : {{(MagW-QuotW){1'b0}}, quot}),
      .prod_o (prod[g])
    );
  end

  assign sum_sq = prod[0] + prod[1] + prod[2];

  bsm_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (root_ctrl),
    .val_i  (sum_sq),
    .root_o (len)
  );

  // decision terms
  assign len_r       = ExcessW'(len) + ExcessW'(rin_q);
  assign excess      = len_r - ExcessW'(acc_r_q);
  assign tot         = (ExcessW+1)'(len_r) + (ExcessW+1)'(acc_r_q);
  assign rad_sat     = |tot[ExcessW:RadW+1];
  assign rad_half_lo = tot[RadW:1];

  bsm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .e_i    (excess),
    .l_i    (len),
    .q_o    (quot)
  );

  // next state and unit strobes
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    lane_ctrl = '0;
    root_ctrl = '0;
    div_ctrl  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = start_new_i ? S_OUT : S_SLD;
        end
      end
      S_SLD: begin
        lane_ctrl.load = 1'b1;
        cnt_d          = '0;
        state_d        = S_SQR;
      end
      S_SQR: begin
        lane_ctrl.step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(MulSteps - 1)) begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        root_ctrl.load = 1'b1;
        cnt_d          = '0;
        state_d        = S_ROOT;
      end
      S_ROOT: begin
        root_ctrl.step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(RootSteps - 1)) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        cnt_d = '0;
        if (len != '0 && len_r > ExcessW'(acc_r_q) &&
            !(ExcessW'(rin_q) > ExcessW'(len) &&
              ExcessW'(rin_q) - ExcessW'(len) > ExcessW'(acc_r_q))) begin
          div_ctrl.load = 1'b1;
          state_d       = S_DIV;
        end else begin
          state_d = S_OUT;
        end
      end
      S_DIV: begin
        div_ctrl.step = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          state_d = S_MLD;
        end
      end
      S_MLD: begin
        lane_ctrl.load = 1'b1;
        cnt_d          = '0;
        state_d        = S_MUL;
      end
      S_MUL: begin
        lane_ctrl.step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(MulSteps - 1)) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // running sphere and per-item operands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        acc_c_q[i] <= '0;
        cin_q[i]   <= '0;
        mag_q[i]   <= '0;
        neg_q[i]   <= 1'b0;
      end
      acc_r_q <= '0;
      rin_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            ovf_q <= 1'b0;
            rin_q <= in_radius_i;
            for (int i = 0; i < 3; i++) begin
              logic [MagW-1:0] d;
              d = {acc_c_q[i][CoordW-1], acc_c_q[i]} - {in_c[i][CoordW-1], in_c[i]};
              cin_q[i] <= in_c[i];
              neg_q[i] <= d[MagW-1];
              mag_q[i] <= d[MagW-1] ? (MagW)'(0) - d : d;
              if (start_new_i) begin
                acc_c_q[i] <= in_c[i];
              end
            end
            if (start_new_i) begin
              acc_r_q <= in_radius_i;
            end
          end
        end
        S_DEC: begin
          if (len == '0) begin
            if (rin_q > acc_r_q) begin
              acc_r_q <= rin_q;
            end
          end else if (len_r > ExcessW'(acc_r_q)) begin
            if (ExcessW'(rin_q) > ExcessW'(len) &&
                ExcessW'(rin_q) - ExcessW'(len) > ExcessW'(acc_r_q)) begin
              for (int i = 0; i < 3; i++) begin
                acc_c_q[i] <= cin_q[i];
              end
              acc_r_q <= rin_q;
            end else begin
              acc_r_q <= rad_sat ? RadMax : rad_half_lo;
              ovf_q   <= rad_sat;
            end
          end
        end
        S_UPD: begin
          // round the offset and step the centre towards the new sphere
          for (int i = 0; i < 3; i++) begin
            logic [ProdW-1:0] rnd;
            logic [MagW-1:0]  off;
            rnd = prod[i] + (ProdW'(1) << (PBits - 1));
            off = rnd[PBits+MagW-1:PBits];
            acc_c_q[i] <= neg_q[i] ? CoordW'({1'b0, acc_c_q[i]} + off)
                                   : CoordW'({1'b0, acc_c_q[i]} - off);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = (state_q == S_OUT);
  assign out_center_x_o = acc_c_q[0];
  assign out_center_y_o = acc_c_q[1];
  assign out_center_z_o = acc_c_q[2];
  assign out_radius_o   = acc_r_q;
  assign overflow_o     = ovf_q;

endmodule
`default_nettype wire

FILE: design/bsm_checker.sv
// ----------------------------------------------------------------------------
// bsm_checker - port-level checks for the bounding sphere merge
// Watches the handshakes and the result payload over time.
// ----------------------------------------------------------------------------
`default_nettype none
module bsm_checker (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        in_ready_o,
  input wire                        out_valid_o,
  input wire                        out_ready_i,
  input wire [bsm_pkg::CoordW-1:0]  out_center_x_o,
  input wire [bsm_pkg::RadW-1:0]    out_radius_o,
  input wire                        overflow_o
);
  import bsm_pkg::*;

  // never take an item while a result waits
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_radius_o) &&
    $stable(out_center_x_o))
    else $error("stalled result changed");

  // one result per item
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o)
    else $error("result repeated");

  // saturation pins the radius
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> out_radius_o == RadMax)
    else $error("overflow without saturated radius");

endmodule

bind bounding_sphere_merge bsm_checker u_bsm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .out_center_x_o (out_center_x_o),
  .out_radius_o   (out_radius_o),
  .overflow_o     (overflow_o)
);
`default_nettype wire

FILE: tb/bounding_sphere_merge_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounding_sphere_merge_test - self-checking bench for the sphere merge
// Streams start and merge spheres through the block under random idling on
// both channels and compares every result with a running-sphere predictor.
// ----------------------------------------------------------------------------
`default_nettype none
module bounding_sphere_merge_test;

  import bsm_pkg::*;

  typedef struct {
    logic [CoordW-1:0] cx, cy, cz;
    logic [RadW-1:0]   rad;
    logic              ovf;
  } sphere_t;

  // Running enclosing sphere plus the queue of spheres it still owes
  class sphere_tracker;
    longint          acc_x, acc_y, acc_z;
    logic [95:0]     acc_r;
    sphere_t         expected_spheres[$];
    int              mismatches;
    int              checked;

    function new();
      acc_x = 0; acc_y = 0; acc_z = 0; acc_r = '0;
      mismatches = 0; checked = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function int pending();
      return expected_spheres.size();
    endfunction

    function longint shift_axis(longint acc, longint d, logic [95:0] p);
      logic [95:0] ad, off;
      ad = (d < 0) ? 96'(-d) : 96'(d);
      off = (ad * p + (96'd1 << (PBits - 1))) >> PBits;
      return (d < 0) ? acc + longint'(off) : acc - longint'(off);
    endfunction

    // Fold one sphere into the running sphere and queue the outcome
    function void note_input(logic st, logic [CoordW-1:0] x, y, z, logic [RadW-1:0] r);
      longint      cx, cy, cz, dx, dy, dz;
      logic [95:0] ax, ay, az, sum, t, l, rr, p, nr;
      logic [33:0] root;
      sphere_t     e;
      cx = longint'($signed(x)); cy = longint'($signed(y)); cz = longint'($signed(z));
      rr = 96'(r);
      e.ovf = 1'b0;
      if (st) begin
        acc_x = cx; acc_y = cy; acc_z = cz; acc_r = rr;
      end else begin
        dx = acc_x - cx; dy = acc_y - cy; dz = acc_z - cz;
        ax = (dx < 0) ? 96'(-dx) : 96'(dx);
        ay = (dy < 0) ? 96'(-dy) : 96'(dy);
        az = (dz < 0) ? 96'(-dz) : 96'(dz);
        sum = ax * ax + ay * ay + az * az;
        root = '0;
        for (int b = 33; b >= 0; b--) begin
          t = 96'(root | (34'd1 << b));
          if (t * t <= sum) root = t[33:0];
        end
        l = 96'(root);
        if (l == 0) begin
          // coincident centres: keep the larger radius
          if (rr > acc_r) acc_r = rr;
        end else if (l + rr > acc_r) begin
          if (rr > l && rr - l > acc_r) begin
            acc_x = cx; acc_y = cy; acc_z = cz; acc_r = rr;
          end else begin
            // partial overlap: pull the centre over and grow the radius
            p = ((l + rr - acc_r) << (PBits - 1)) / l;
            nr = (acc_r + l + rr) >> 1;
            acc_x = shift_axis(acc_x, dx, p);
            acc_y = shift_axis(acc_y, dy, p);
            acc_z = shift_axis(acc_z, dz, p);
            if (nr > 96'(RadMax)) begin
              nr = 96'(RadMax);
              e.ovf = 1'b1;
            end
            acc_r = nr;
          end
        end
      end
      e.cx = acc_x[31:0]; e.cy = acc_y[31:0]; e.cz = acc_z[31:0];
      e.rad = acc_r[RadW-1:0];
      expected_spheres = {expected_spheres, e};
    endfunction

    task check_result(logic [CoordW-1:0] x, y, z, logic [RadW-1:0] r, logic ovf);
      sphere_t e;
      if (expected_spheres.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      e = expected_spheres.pop_front();
      checked++;
      if (x !== e.cx) report($sformatf("centre x %h, expected %h", x, e.cx));
      if (y !== e.cy) report($sformatf("centre y %h, expected %h", y, e.cy));
      if (z !== e.cz) report($sformatf("centre z %h, expected %h", z, e.cz));
      if (r !== e.rad) report($sformatf("radius %h, expected %h", r, e.rad));
      if (ovf !== e.ovf) report($sformatf("overflow %b, expected %b", ovf, e.ovf));
    endtask
  endclass

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned HoldCycles = 600;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              start_new_i = 1'b0;
  logic [CoordW-1:0] in_center_x_i = '0;
  logic [CoordW-1:0] in_center_y_i = '0;
  logic [CoordW-1:0] in_center_z_i = '0;
  logic [RadW-1:0]   in_radius_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [CoordW-1:0] out_center_x_o, out_center_y_o, out_center_z_o;
  logic [RadW-1:0]   out_radius_o;
  logic              overflow_o;

  sphere_tracker tracker = new();
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  bit  drain_done = 1'b0;
  int  quiet_cycles = 0;
  int  sent_items = 0;
  int  starts_sent = 0;

  bounding_sphere_merge uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .start_new_i,
    .in_center_x_i, .in_center_y_i, .in_center_z_i, .in_radius_i,
    .out_valid_o, .out_ready_i, .out_center_x_o, .out_center_y_o,
    .out_center_z_o, .out_radius_o, .overflow_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Note inputs and check results on transfer; watch for a hung block
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o)
      tracker.note_input(start_new_i, in_center_x_i, in_center_y_i, in_center_z_i,
                         in_radius_i);
    if (out_valid_o && out_ready_i)
      tracker.check_result(out_center_x_o, out_center_y_o, out_center_z_o,
                           out_radius_o, overflow_o);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("bounding_sphere_merge_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, or a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one sphere, idling first at random, and hold it until transfer
  task send_sphere(logic st, logic [CoordW-1:0] x, y, z, logic [RadW-1:0] r);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    start_new_i   <= st;
    in_center_x_i <= x;
    in_center_y_i <= y;
    in_center_z_i <= z;
    in_radius_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    sent_items++;
    if (st) starts_sent++;
  endtask

  function logic [CoordW-1:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return CoordW'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
      2: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(255)
                                  : 32'h8000_0000 + $urandom_range(255);
      default: return CoordW'($urandom_range(0, 32'h400)) - 32'h200;
    endcase
  endfunction

  function logic [RadW-1:0] rand_radius();
    case ($urandom_range(3))
      0: return RadW'($urandom());
      1: return RadW'($urandom_range(0, 32'h20_0000));
      2: return RadMax - RadW'($urandom_range(255));
      default: return RadW'($urandom_range(0, 32'h400));
    endcase
  endfunction

  // A start followed by a run of merges with random content
  task send_pass(int merges);
    send_sphere(1'b1, rand_coord(), rand_coord(), rand_coord(), rand_radius());
    for (int i = 0; i < merges; i++) begin
      if ($urandom_range(9) == 0)
        // reuse the last centre to hit the coincident case
        send_sphere(1'b0, in_center_x_i, in_center_y_i, in_center_z_i, rand_radius());
      else
        send_sphere(1'b0, rand_coord(), rand_coord(), rand_coord(), rand_radius());
    end
  endtask

  task wait_drained();
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: merge into the reset sphere, then the extremes and each case
    send_sphere(1'b0, 32'h0001_0000, 32'h0, 32'h0, 31'h0002_0000);
    send_sphere(1'b0, 32'h0, 32'h0, 32'h0, 31'h0);
    send_sphere(1'b1, 32'h0, 32'h0, 32'h0, 31'h0001_0000);
    send_sphere(1'b0, 32'h0, 32'h0, 32'h0, 31'h0003_0000);   // same centre, larger
    send_sphere(1'b0, 32'h0, 32'h0, 32'h0, 31'h0000_8000);   // same centre, smaller
    send_sphere(1'b0, 32'h0001_0000, 32'h0, 32'h0, 31'h0000_1000); // inside
    send_sphere(1'b0, 32'h0004_0000, 32'h0, 32'h0, 31'h0002_0000); // partial
    send_sphere(1'b0, 32'h0001_0000, 32'h0001_0000, 32'h0, 31'h0010_0000); // encloses
    send_sphere(1'b0, 32'hFFF0_0000, 32'h0030_0000, 32'hFFFF_0000, 31'h0001_0000);
    send_sphere(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, RadMax);
    send_sphere(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, RadMax); // saturates
    send_sphere(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h0);
    send_sphere(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h0);
    send_sphere(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h0);
    send_sphere(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, RadMax);
    send_sphere(1'b1, 32'h0, 32'h0, 32'h0, 31'h0);
    send_sphere(1'b0, 32'h0, 32'h0, 32'h1, 31'h0);            // one-LSB distance
    send_sphere(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h1);
    send_sphere(1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 31'h2AAA_AAAA);
    send_sphere(1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC, 31'h5555_5555);

    // Random passes under three idling mixes
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 56 : 0;
      recv_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 18 : 0;
      while (sent_items < 20 + 410 * (ph + 1)) begin
        if (ph == 0 && !hold_done && sent_items >= 200) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        if (ph == 1 && !drain_done && sent_items >= 700) begin
          drain_done = 1'b1;
          in_valid_i <= 1'b0;
          wait_drained();
        end
        send_pass($urandom_range(1, 12));
      end
    end
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (200) @(posedge clk_i);
    $display("Sent %0d spheres in %0d passes; checked %0d merged results.",
             sent_items, starts_sent, tracker.checked);
    $display("Covered coincident, enclosed, enclosing, partial and saturating merges.");
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("bounding_sphere_merge_test OK");
    end else begin
      $display("bounding_sphere_merge_test NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
